// ===== sv/cht_pkg.sv =====
// Package for the chained hash table: request/result and control structs, codes, sizes.
// Used by every module of the block but cht_ram; depends on nothing.
package cht_pkg;

    localparam int BUCKETS_DEF = 64;
    localparam int NODES_DEF   = 256;
    localparam int KEY_W       = 31;
    localparam int POS_W       = 9;
    localparam int NB_W        = 7;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_SEARCH = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             status;
    } rsp_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // capture request, start modulo
        logic mod_step;   // one restoring-division step
        logic head_rd;    // read bucket head (walk start)
        logic clear;      // write null into the next bucket head after reset
        logic advance;    // prev <= cur, cur <= link, pos++
        logic do_insert;  // write new node, relink head, allocate
        logic do_unlink;  // relink around cur
        logic do_free;    // cur onto free list
        logic found;      // latch position as result
        logic fail;       // latch zero / full result
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic mod_done;
        logic cur_nil;
        logic key_match;
        logic pos_over;
        logic can_alloc;
        logic clr_done;
        logic [1:0] req_type;
    } sts_t;

endpackage

// ===== sv/cht_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/cht_datapath.sv =====
// Datapath of the chained hash table: bucket heads, node memories, free list,
// bit-serial modulo and chain-walk registers. Depends on cht_pkg and cht_ram.
module cht_datapath
    import cht_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int NODES   = NODES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  req_t            req,
    input  logic [NB_W-1:0] num_buckets,
    input  cmd_t            cmd,
    output sts_t            sts,
    output rsp_t            rsp
);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW = $clog2(NODES + 1);   // holds null = NODES
    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam logic [NW-1:0] NIL = NW'(NODES);
    localparam int MW = (NB_W > BW + 1) ? NB_W : BW + 1;

    req_t              req_reg;
    logic [KEY_W-1:0]  quo_reg;
    logic [MW-1:0]     rem_reg;
    logic [MW-1:0]     mod_val;
    logic [5:0]        bit_cnt_reg;
    logic [NW-1:0]     cur_reg, prev_reg, free_head_reg, cur_link;
    logic [NW:0]       fresh_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [NW:0]       pos_cnt_reg;
    rsp_t              rsp_reg;
    logic [KEY_W-1:0]  rd_key;
    logic [NW-1:0]     rd_link;
    logic [BW:0]       clr_reg;
    logic [NW-1:0]     head_rdata;
    logic              heads_we;
    logic [BW-1:0]     heads_waddr;
    logic [NW-1:0]     heads_wdata;
    logic [BW-1:0]     bucket;
    logic              key_we, link_we;
    logic [AW-1:0]     key_waddr, link_waddr, rd_addr;
    logic [NW-1:0]     link_wdata;
    logic [NW-1:0]     new_node;
    logic [MW:0]       trial;

    // Effective modulus: 0 counts as 1, above BUCKETS clamps.
    always_comb
    begin
        if (num_buckets == '0)
        begin
            mod_val = MW'(1);
        end
        else if (32'(num_buckets) > BUCKETS)
        begin
            mod_val = MW'(BUCKETS);
        end
        else
        begin
            mod_val = MW'(num_buckets);
        end
    end

    assign trial  = {rem_reg, quo_reg[KEY_W-1]};
    assign bucket = BW'(rem_reg);
    assign new_node = (free_head_reg != NIL) ? free_head_reg : NW'(fresh_reg);
    assign cur_link = rd_link;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg     <= req;
            quo_reg     <= req.key;
            rem_reg     <= '0;
            bit_cnt_reg <= '0;
        end
        else if (cmd.mod_step)
        begin
            quo_reg     <= {quo_reg[KEY_W-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg + 6'd1;
            if (trial >= {1'b0, mod_val})
            begin
                rem_reg <= MW'(trial - {1'b0, mod_val});
            end
            else
            begin
                rem_reg <= MW'(trial);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            free_head_reg <= NIL;
            fresh_reg     <= '0;
            cur_reg       <= NIL;
            prev_reg      <= NIL;
            pos_reg       <= '0;
            pos_cnt_reg   <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + (BW+1)'(1);
            end
            if (cmd.head_rd)
            begin
                cur_reg     <= head_rdata;
                prev_reg    <= NIL;
                pos_reg     <= POS_W'(1);
                pos_cnt_reg <= (NW+1)'(1);
            end
            if (cmd.advance)
            begin
                prev_reg    <= cur_reg;
                cur_reg     <= cur_link;
                pos_reg     <= pos_reg + POS_W'(1);
                pos_cnt_reg <= pos_cnt_reg + (NW+1)'(1);
            end
            if (cmd.do_insert)
            begin
                rsp_reg.position <= '0;
                rsp_reg.status   <= STATUS_DONE;
                if (free_head_reg != NIL)
                begin
                    free_head_reg <= rd_link;
                end
                else
                begin
                    fresh_reg <= fresh_reg + (NW+1)'(1);
                end
            end
            if (cmd.do_free)
            begin
                free_head_reg <= cur_reg;
            end
            if (cmd.found)
            begin
                rsp_reg.position <= pos_reg;
                rsp_reg.status   <= STATUS_DONE;
            end
            if (cmd.fail)
            begin
                rsp_reg.position <= '0;
                rsp_reg.status   <= (req_reg.req_type == REQ_INSERT) ? STATUS_FULL
                                                                     : STATUS_DONE;
            end
        end
    end

    // Bucket head writes: clearing pass, new chain head, or unlink of the head node.
    always_comb
    begin
        heads_we    = 1'b0;
        heads_waddr = bucket;
        heads_wdata = NIL;
        if (cmd.clear)
        begin
            heads_we    = 1'b1;
            heads_waddr = BW'(clr_reg);
        end
        else if (cmd.do_insert)
        begin
            heads_we    = 1'b1;
            heads_wdata = new_node;
        end
        else if (cmd.do_unlink && prev_reg == NIL)
        begin
            heads_we    = 1'b1;
            heads_wdata = cur_link;
        end
    end

    // Node read address: free head when popping on insert, else cur.
    always_comb
    begin
        if (req_reg.req_type == REQ_INSERT)
        begin
            rd_addr = AW'(free_head_reg);
        end
        else
        begin
            rd_addr = AW'(cur_reg);
        end
    end

    always_comb
    begin
        key_we     = cmd.do_insert;
        key_waddr  = AW'(new_node);
        link_we    = 1'b0;
        link_waddr = AW'(new_node);
        link_wdata = head_rdata;
        if (cmd.do_insert)
        begin
            link_we = 1'b1;
        end
        else if (cmd.do_unlink && prev_reg != NIL)
        begin
            link_we    = 1'b1;
            link_waddr = AW'(prev_reg);
            link_wdata = cur_link;
        end
        else if (cmd.do_free)
        begin
            link_we    = 1'b1;
            link_waddr = AW'(cur_reg);
            link_wdata = free_head_reg;
        end
    end

    // The bucket stays fixed from the end of the modulo on, so the head read
    // data is valid from the dispatch cycle onward.
    cht_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_heads (
        .clk   (clk),
        .we    (heads_we),
        .waddr (heads_waddr),
        .wdata (heads_wdata),
        .raddr (bucket),
        .rdata (head_rdata)
    );

    cht_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_keys (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (req_reg.key),
        .raddr (rd_addr),
        .rdata (rd_key)
    );

    cht_ram #(.WIDTH(NW), .DEPTH(NODES)) u_links (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (rd_addr),
        .rdata (rd_link)
    );

    assign sts.mod_done  = (bit_cnt_reg == 6'(KEY_W));
    assign sts.cur_nil   = (cur_reg == NIL);
    assign sts.key_match = (rd_key == req_reg.key);
    assign sts.pos_over  = (pos_cnt_reg > (NW+1)'(NODES));
    assign sts.clr_done  = (clr_reg == (BW+1)'(BUCKETS));
    assign sts.can_alloc = (free_head_reg != NIL) || (fresh_reg < (NW+1)'(NODES));
    assign sts.req_type  = req_reg.req_type;
    assign rsp           = rsp_reg;
endmodule

// ===== sv/cht_ctrl.sv =====
// Controller state machine of the chained hash table: sequences modulo,
// chain walk, relinking and the result handshake. Depends on cht_pkg.
module cht_ctrl
    import cht_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  sts_t sts,
    output cmd_t cmd
);
    typedef enum logic [8:0] {
        S_CLEAR  = 9'b0_0000_0001,
        S_IDLE   = 9'b0_0000_0010,
        S_MOD    = 9'b0_0000_0100,
        S_DISP   = 9'b0_0000_1000,
        S_RDWAIT = 9'b0_0001_0000,
        S_CMP    = 9'b0_0010_0000,
        S_FREE   = 9'b0_0100_0000,
        S_INS    = 9'b0_1000_0000,
        S_OUT    = 9'b1_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.clear = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (sts.mod_done)
                begin
                    state_next = S_DISP;
                end
                else
                begin
                    cmd.mod_step = 1'b1;
                end
            end
            S_DISP:
            begin
                if (sts.req_type == REQ_INSERT)
                begin
                    if (sts.can_alloc)
                    begin
                        // Free-list link of the popped node is read first.
                        state_next = S_INS;
                    end
                    else
                    begin
                        cmd.fail   = 1'b1;
                        state_next = S_OUT;
                    end
                end
                else if (sts.req_type == REQ_SEARCH || sts.req_type == REQ_DELETE)
                begin
                    cmd.head_rd = 1'b1;
                    state_next  = S_RDWAIT;
                end
                else
                begin
                    cmd.fail   = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_INS:
            begin
                cmd.do_insert = 1'b1;
                state_next    = S_OUT;
            end
            S_RDWAIT:
            begin
                if (sts.cur_nil || sts.pos_over)
                begin
                    cmd.fail   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (sts.key_match)
                begin
                    cmd.found = 1'b1;
                    if (sts.req_type == REQ_DELETE)
                    begin
                        cmd.do_unlink = 1'b1;
                        state_next    = S_FREE;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_RDWAIT;
                end
            end
            S_FREE:
            begin
                cmd.do_free = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ===== sv/chained_hash_table.sv =====
// Top level of the chained hash table: config register, controller, datapath.
// Depends on cht_pkg, cht_ctrl and cht_datapath.
//
// Requests (insert, search, delete of a 31-bit key) enter on in_valid/in_stall
// and each yields one result (position, status) on out_valid/out_stall.
// The bucket is key mod num_buckets, computed by a bit-serial divider of one
// bit per cycle. A chain walk then visits each node in the states S_RDWAIT
// and S_CMP, since the node memories have a registered read. One request is
// in flight at a time; in_stall is high until its result has been taken, and
// the next request can be accepted in the cycle after that. The result
// register holds while out_stall is high. num_buckets is written on
// cfg_valid/cfg_ready, always ready; write it only while the block is idle.
// After reset a clearing pass writes null into every bucket head, with
// in_stall high; node memories need no clearing pass.
module chained_hash_table
    import cht_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int NODES   = NODES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  req_t            in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output rsp_t            out_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [NB_W-1:0] cfg_data
);
    logic [NB_W-1:0] num_buckets_reg;
    cmd_t            cmd;
    sts_t            sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_buckets_reg <= NB_W'(BUCKETS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            num_buckets_reg <= cfg_data;
        end
    end

    cht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    cht_datapath #(.BUCKETS(BUCKETS), .NODES(NODES)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (in_data),
        .num_buckets (num_buckets_reg),
        .cmd         (cmd),
        .sts         (sts),
        .rsp         (out_data)
    );
endmodule

// ===== sv/cht_checker.sv =====
// Port-level checker for the chained hash table, bound to the top level.
// Depends on cht_pkg.
module cht_checker
    import cht_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input rsp_t out_data
);
    // A request accepted means a busy block in the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall) else $error("not busy after request");

    // The block never takes a request while a result is offered.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("request taken with result pending");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // A refused insert never carries a position.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |-> out_data.position == '0)
        else $error("full status with position");
endmodule

bind chained_hash_table cht_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
